FILE: hdl/bncv_pkg.sv
// Shared constants, command codes and the job type for the net-charge variance block.
package bncv_pkg;

   localparam int NUM_BINS   = 256;
   localparam int COUNT_BITS = 24;
   localparam int ADDR_W     = $clog2(NUM_BINS);
   localparam int WORD_W     = COUNT_BITS + 34 + 40;
   localparam int Q_DEPTH    = 4;
   localparam int Q_PTR_W    = $clog2(Q_DEPTH);
   localparam int DIV_STEPS  = 34;

   // command codes on req_tuser
   localparam logic [1:0] CMD_TRACK = 2'd0;
   localparam logic [1:0] CMD_EOE   = 2'd1;
   localparam logic [1:0] CMD_READ  = 2'd2;

   // register indexes on the csr port
   localparam logic [1:0] REG_PT_THR  = 2'd0;
   localparam logic [1:0] REG_ETA_LIM = 2'd1;

   // one job handed from the front to the back
   typedef struct packed {
      logic              is_read;
      logic              idx_ok;
      logic [ADDR_W-1:0] addr;
      logic signed [9:0] charge;
   } job_type;

endpackage

FILE: hdl/bncv_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module bncv_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

FILE: hdl/bncv_queue.sv
// Short job queue between the classifying front and the bin back end.
module bncv_queue
   import bncv_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  job_type push_job,
   output logic    full,
   input  logic    pop,
   output job_type pop_job,
   output logic    empty
);

   job_type            q_ff [Q_DEPTH];
   logic [Q_PTR_W-1:0] wptr_ff, wptr_in;
   logic [Q_PTR_W-1:0] rptr_ff, rptr_in;
   logic [Q_PTR_W:0]   cnt_ff, cnt_in;

   assign full    = (cnt_ff == (Q_PTR_W+1)'(Q_DEPTH));
   assign empty   = (cnt_ff == '0);
   assign pop_job = q_ff[rptr_ff];

   // pointer and fill count
   always_comb begin
      wptr_in = wptr_ff;
      rptr_in = rptr_ff;
      cnt_in  = cnt_ff;
      if (push && !full) begin
         wptr_in = wptr_ff + 1'b1;
      end
      if (pop && !empty) begin
         rptr_in = rptr_ff + 1'b1;
      end
      if ((push && !full) && !(pop && !empty)) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (!(push && !full) && (pop && !empty)) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= '0;
         rptr_ff <= '0;
         cnt_ff  <= '0;
      end else begin
         wptr_ff <= wptr_in;
         rptr_ff <= rptr_in;
         cnt_ff  <= cnt_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (push && !full) begin
         q_ff[wptr_ff] <= push_job;
      end
   end

endmodule

FILE: hdl/bncv_front.sv
// Front end: config registers, track cuts, per-event accumulation and job issue.
module bncv_front
   import bncv_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [71:0] req_tdata,
   input  logic [1:0]  req_tuser,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_data,
   input  logic        clear_busy,
   input  logic        q_full,
   output logic        q_push,
   output job_type     q_job
);

   // net charge limits of the 10-bit event accumulator
   localparam logic signed [9:0] NET_MAX = 10'sd511;
   localparam logic signed [9:0] NET_MIN = -10'sd511 - 10'sd1;

   logic [15:0]       pt_thr_ff;
   logic [12:0]       eta_lim_ff;
   logic [7:0]        mult_ff, mult_in;
   logic signed [9:0] net_ff, net_in;

   logic [15:0]        pt;
   logic signed [13:0] eta;
   logic [13:0]        eta_abs;
   logic [31:0]        pid;
   logic [7:0]         idx;
   logic               acc;
   logic               pass;

   assign csr_ready  = 1'b1;
   assign req_tready = !clear_busy && !q_full;
   assign acc        = req_tvalid && req_tready;

   // unpack the word
   assign pt      = req_tdata[15:0];
   assign eta     = req_tdata[29:16];
   assign pid     = req_tdata[61:30];
   assign idx     = req_tdata[69:62];
   assign eta_abs = eta[13] ? 14'(-eta) : 14'(eta);
   assign pass    = (pt > pt_thr_ff) && (eta_abs < {1'b0, eta_lim_ff});

   // event accumulators and job issue
   always_comb begin
      mult_in      = mult_ff;
      net_in       = net_ff;
      q_push       = 1'b0;
      q_job        = '0;
      q_job.charge = net_ff;
      if (int'(mult_ff) > NUM_BINS - 1) begin
         q_job.addr = ADDR_W'(NUM_BINS - 1);
      end else begin
         q_job.addr = ADDR_W'(mult_ff);
      end
      if (acc) begin
         unique case (req_tuser)
            CMD_TRACK: begin
               if (pass) begin
                  if (mult_ff != 8'hFF) begin
                     mult_in = mult_ff + 1'b1;
                  end
                  if (pid != '0) begin
                     if (pid[31] && net_ff != NET_MIN) begin
                        net_in = net_ff - 10'sd1;
                     end else if (!pid[31] && net_ff != NET_MAX) begin
                        net_in = net_ff + 10'sd1;
                     end
                  end
               end
            end
            CMD_EOE: begin
               q_push  = 1'b1;
               mult_in = '0;
               net_in  = '0;
            end
            CMD_READ: begin
               q_push        = 1'b1;
               q_job.is_read = 1'b1;
               q_job.idx_ok  = (int'(idx) < NUM_BINS);
               q_job.addr    = ADDR_W'(idx);
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pt_thr_ff  <= 16'd50;
         eta_lim_ff <= 13'd1024;
         mult_ff    <= '0;
         net_ff     <= '0;
      end else begin
         mult_ff <= mult_in;
         net_ff  <= net_in;
         if (csr_valid) begin
            case (csr_index)
               REG_PT_THR:  pt_thr_ff  <= csr_data;
               REG_ETA_LIM: eta_lim_ff <= csr_data[12:0];
               default: begin
               end
            endcase
         end
      end
   end

endmodule

FILE: hdl/bncv_back.sv
// Back end: bin memory with clear sweep, end-of-event update, readout and variance divider.
module bncv_back
   import bncv_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         q_empty,
   output logic         q_pop,
   input  job_type      q_job,
   output logic         clear_busy,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [135:0] rsp_tdata
);

   localparam logic [3:0] ST_CLEAR  = 4'd0;
   localparam logic [3:0] ST_IDLE   = 4'd1;
   localparam logic [3:0] ST_DATA   = 4'd2;
   localparam logic [3:0] ST_MUL_LO = 4'd3;
   localparam logic [3:0] ST_MUL_HI = 4'd4;
   localparam logic [3:0] ST_SQ     = 4'd5;
   localparam logic [3:0] ST_DEN    = 4'd6;
   localparam logic [3:0] ST_PREP   = 4'd7;
   localparam logic [3:0] ST_DIV    = 4'd8;
   localparam logic [3:0] ST_OUT    = 4'd9;

   localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

   logic [3:0]        state_ff, state_in;
   logic [ADDR_W-1:0] clr_ff, clr_in;
   logic [5:0]        step_ff, step_in;
   logic              rsp_valid_ff, rsp_valid_in;

   job_type                  job_ff, job_in;
   logic [COUNT_BITS-1:0]    n_ff, n_in;
   logic signed [33:0]       s1_ff, s1_in;
   logic [39:0]              s2_ff, s2_in;
   logic [COUNT_BITS+19:0]   plo_ff, plo_in, phi_ff, phi_in;
   logic [63:0]              sq_ff, sq_in, prod_ff, prod_in;
   logic [2*COUNT_BITS-1:0]  d_ff, d_in;
   logic [79:0]              rem_ff, rem_in;
   logic [80:0]              dsh_ff, dsh_in;
   logic [33:0]              quo_ff, quo_in;
   logic [135:0]             rsp_data_ff, rsp_data_in;

   logic                    wr_en, rd_en;
   logic [ADDR_W-1:0]       wr_addr;
   logic [WORD_W-1:0]       wr_data, rd_data;
   logic [COUNT_BITS-1:0]   r_cnt;
   logic signed [33:0]      r_s1;
   logic [39:0]             r_s2;
   logic signed [19:0]      q2s;
   logic [40:0]             s2_sum;
   logic [33:0]             mag;
   logic [63:0]             num;
   logic                    out_free;

   bncv_ram #(.WIDTH(WORD_W), .DEPTH(NUM_BINS)) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (q_job.addr),
      .rd_data (rd_data)
   );

   assign r_cnt      = rd_data[COUNT_BITS-1:0];
   assign r_s1       = rd_data[COUNT_BITS+33:COUNT_BITS];
   assign r_s2       = rd_data[WORD_W-1:COUNT_BITS+34];
   assign q2s        = job_ff.charge * job_ff.charge;
   assign s2_sum     = {1'b0, r_s2} + 41'(unsigned'(q2s));
   assign mag        = s1_ff[33] ? 34'(-s1_ff) : 34'(s1_ff);
   assign num        = prod_ff - sq_ff;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign clear_busy = (state_ff == ST_CLEAR);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // sequencer
   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      step_in      = step_ff;
      rsp_valid_in = rsp_valid_ff;
      job_in       = job_ff;
      n_in         = n_ff;
      s1_in        = s1_ff;
      s2_in        = s2_ff;
      plo_in       = plo_ff;
      phi_in       = phi_ff;
      sq_in        = sq_ff;
      prod_in      = prod_ff;
      d_in         = d_ff;
      rem_in       = rem_ff;
      dsh_in       = dsh_ff;
      quo_in       = quo_ff;
      rsp_data_in  = rsp_data_ff;
      wr_en        = 1'b0;
      wr_addr      = job_ff.addr;
      wr_data      = '0;
      rd_en        = 1'b0;
      q_pop        = 1'b0;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      unique case (state_ff)
         ST_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = clr_ff;
            clr_in  = clr_ff + 1'b1;
            if (int'(clr_ff) == NUM_BINS - 1) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (!q_empty) begin
               q_pop    = 1'b1;
               rd_en    = 1'b1;
               job_in   = q_job;
               state_in = ST_DATA;
            end
         end
         ST_DATA: begin
            if (job_ff.is_read) begin
               n_in     = job_ff.idx_ok ? r_cnt : '0;
               s1_in    = job_ff.idx_ok ? r_s1 : '0;
               s2_in    = job_ff.idx_ok ? r_s2 : '0;
               state_in = ST_MUL_LO;
            end else begin
               // end of event: read-modify-write unless the bin is full
               wr_en   = (r_cnt != COUNT_MAX);
               wr_data = {(s2_sum[40] ? 40'hFF_FFFF_FFFF : s2_sum[39:0]),
                          34'(r_s1 + 34'(job_ff.charge)), r_cnt + 1'b1};
               state_in = ST_IDLE;
            end
         end
         ST_MUL_LO: begin
            plo_in   = n_ff * s2_ff[19:0];
            state_in = ST_MUL_HI;
         end
         ST_MUL_HI: begin
            phi_in   = n_ff * s2_ff[39:20];
            state_in = ST_SQ;
         end
         ST_SQ: begin
            sq_in    = mag[31:0] * mag[31:0];
            state_in = ST_DEN;
         end
         ST_DEN: begin
            d_in     = n_ff * (n_ff - 1'b1);
            prod_in  = 64'(plo_ff) + (64'(phi_ff) << 20);
            state_in = ST_PREP;
         end
         ST_PREP: begin
            rem_in  = {num, 16'd0};
            dsh_in  = 81'(d_ff) << 33;
            quo_in  = '0;
            step_in = '0;
            if (n_ff < COUNT_BITS'(2) || (|mag[33:32]) || sq_ff > prod_ff) begin
               state_in = ST_OUT;
            end else if (66'(num) >= (66'(d_ff) << 18)) begin
               quo_in   = '1;
               state_in = ST_OUT;
            end else begin
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            // one quotient bit a cycle, most significant first
            if ({1'b0, rem_ff} >= dsh_ff) begin
               rem_in = rem_ff - dsh_ff[79:0];
               quo_in = {quo_ff[32:0], 1'b1};
            end else begin
               quo_in = {quo_ff[32:0], 1'b0};
            end
            dsh_in  = dsh_ff >> 1;
            step_in = step_ff + 1'b1;
            if (int'(step_ff) == DIV_STEPS - 1) begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {2'b00,
                               job_ff.idx_ok && (n_ff == COUNT_MAX),
                               n_ff > COUNT_BITS'(1),
                               quo_ff, s2_ff, s1_ff, 24'(n_ff)};
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      job_ff      <= job_in;
      n_ff        <= n_in;
      s1_ff       <= s1_in;
      s2_ff       <= s2_in;
      plo_ff      <= plo_in;
      phi_ff      <= phi_in;
      sq_ff       <= sq_in;
      prod_ff     <= prod_in;
      d_ff        <= d_in;
      rem_ff      <= rem_in;
      dsh_ff      <= dsh_in;
      quo_ff      <= quo_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

FILE: hdl/binned_net_charge_variance.sv
// Top level of the binned net-charge variance accumulator.
//
// req channel: one word per track, end of event or bin read. req_tuser holds the
// command (0 track, 1 end of event, 2 read, 3 ignored). Tracks are taken one per
// cycle while req_tready is high and only update the event multiplicity and net
// charge in the front end. End of event and read words go into a four-deep queue to
// the back end, which takes an end of event through a bin read, then a bin write.
// A read runs from leaving the queue to the response through the bin read, four
// multiply steps, a check, the radix-2 divider and the output load. The divider
// sets the read rate; the bin memory port sets the event rate.
// rsp channel: one word per read, held in an output register; while the
// receiver stalls the back end holds at its output step and the queue fills,
// after which req_tready drops.
// csr channel: index 0 pT threshold, 1 eta limit; always ready.
// Reset: synchronous; after it the back end sweeps the bin memory to zero,
// one bin per cycle over all NUM_BINS bins (256 by default), with req_tready low.
module binned_net_charge_variance
   import bncv_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // pt_mev[15:0], eta_fixed[29:16], particle_id[61:30], bin_index[69:62], zero pad
   input  logic [71:0]  req_tdata,
   // cmd[1:0]
   input  logic [1:0]   req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // bin_count[23:0], charge_sum[57:24], charge_square_sum[97:58],
   // variance_q16[131:98], variance_valid[132], count_saturated[133], zero pad
   output logic [135:0] rsp_tdata,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [1:0]   csr_index,
   input  logic [15:0]  csr_data
);

   logic    clear_busy;
   logic    q_full, q_empty, q_push, q_pop;
   job_type push_job, pop_job;

   bncv_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .clear_busy (clear_busy),
      .q_full     (q_full),
      .q_push     (q_push),
      .q_job      (push_job)
   );

   bncv_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_job (push_job),
      .full     (q_full),
      .pop      (q_pop),
      .pop_job  (pop_job),
      .empty    (q_empty)
   );

   bncv_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_empty    (q_empty),
      .q_pop      (q_pop),
      .q_job      (pop_job),
      .clear_busy (clear_busy),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

FILE: hdl/bncv_checker.sv
// Port-level checks for the net-charge variance block, bound to the top level.
module bncv_checker (
   input logic         clock,
   input logic         reset,
   input logic         req_tvalid,
   input logic         req_tready,
   input logic [71:0]  req_tdata,
   input logic [1:0]   req_tuser,
   input logic         rsp_tvalid,
   input logic         rsp_tready,
   input logic [135:0] rsp_tdata,
   input logic         csr_valid,
   input logic         csr_ready,
   input logic [1:0]   csr_index,
   input logic [15:0]  csr_data
);

   // no response straight after reset
   a_rst_quiet: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("response valid after reset");

   // a stalled response word holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response word changed while stalled");

   // variance flag follows the count
   a_vvalid: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[132] == (rsp_tdata[23:0] > 24'd1)))
      else $error("variance_valid disagrees with bin_count");

   // no variance without enough events
   a_vzero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[132] |-> rsp_tdata[131:98] == '0)
      else $error("variance non-zero for small bin");

   // saturation flag only on a full count
   a_sat: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[133] |-> rsp_tdata[23:0] == 24'hFF_FFFF)
      else $error("count_saturated on a count below full");

endmodule

bind binned_net_charge_variance bncv_checker u_bncv_checker (.*);
